### sv/mbwm_pkg.sv
// ----------------------------------------------------------------------------
// mbwm_pkg
// Types, constants and the CRC-16/MODBUS byte update shared by the
// write-multiple-registers handler.
// ----------------------------------------------------------------------------
package mbwm_pkg;

    localparam int unsigned POS_W      = 9;
    localparam int unsigned HDR_LEN    = 6;
    localparam int unsigned DATA_START = 7;
    localparam int unsigned REPLY_LEN  = 8;
    localparam int unsigned ADDR_W     = 12;
    localparam int unsigned CMD_DEPTH  = 4;
    localparam int unsigned CMD_PTR_W  = 2;

    localparam logic [POS_W-1:0] POS_MAX  = 9'd511;
    localparam logic [15:0]      CRC_INIT = 16'hFFFF;
    localparam logic [15:0]      CRC_POLY = 16'hA001;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       frame_end;
    } mbwm_in_t;

    typedef struct packed {
        logic [7:0] tx_byte;
        logic       tx_last;
    } mbwm_out_t;

    typedef struct packed {
        logic                       write_en;
        logic                       reply_en;
        logic [ADDR_W-1:0]          addr;
        logic [15:0]                data;
        logic [HDR_LEN-1:0][7:0]    hdr;
        logic [15:0]                crc;
    } mbwm_cmd_t;

    function automatic logic [15:0] crc_feed(logic [15:0] crc, logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++)
        begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

endpackage

### sv/modbus_write_multiple_handler_unit.sv
// ----------------------------------------------------------------------------
// modbus_write_multiple_handler_unit
// Modbus RTU function-16 request handler with register bank and reply
// serializer.
// ----------------------------------------------------------------------------
// After reset the block fills its REG_COUNT-entry register bank with 1..N,
// one entry per cycle, and holds full high while it does so. It then takes
// one request byte per cycle while full is low; the front end turns register
// writes and replies into commands for a four-entry command queue, and full
// stays high while that queue is full. On the last byte
// of a frame of eight bytes or more the back end sends the eight-byte reply
// (header echo, CRC low then high) at one byte per cycle while the output is
// taken: the popped command loads the serializer state, and each byte then
// passes through the output register; a reply is eight output bytes.
// ----------------------------------------------------------------------------
module modbus_write_multiple_handler_unit #(
    parameter int unsigned REG_COUNT = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  mbwm_pkg::mbwm_in_t  rx,
    output logic                empty,
    input  logic                pop,
    output mbwm_pkg::mbwm_out_t tx
);
    import mbwm_pkg::*;

    logic      accept;
    logic      cmd_push;
    mbwm_cmd_t cmd_in;
    mbwm_cmd_t cmd_out;
    logic      fifo_full;
    logic      fifo_empty;
    logic      cmd_pop;
    logic      init_busy;
    logic      tx_valid;

    assign full   = fifo_full || init_busy;
    assign accept = push && !full;
    assign empty  = !tx_valid;

    mbwm_front #(
        .REG_COUNT (REG_COUNT)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .rx       (rx),
        .cmd_push (cmd_push),
        .cmd      (cmd_in)
    );

    mbwm_cmd_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr_en      (cmd_push),
        .wr_data    (cmd_in),
        .fifo_full  (fifo_full),
        .rd_en      (cmd_pop),
        .rd_data    (cmd_out),
        .fifo_empty (fifo_empty)
    );

    mbwm_back #(
        .REG_COUNT (REG_COUNT)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (!fifo_empty),
        .cmd       (cmd_out),
        .cmd_pop   (cmd_pop),
        .init_busy (init_busy),
        .tx_valid  (tx_valid),
        .tx        (tx),
        .pop       (pop)
    );

`ifndef NO_ASSERTIONS
    a_no_fifo_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_push |-> !fifo_full)
        else $error("command pushed into a full queue");

    a_quiet_during_init: assert property (@(posedge clk) disable iff (!rst_n)
        init_busy |-> (empty && fifo_empty))
        else $error("activity during bank fill");

    a_reply_needs_queue: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !tx.tx_last && pop) |=> !empty)
        else $error("reply broken before its last byte");
`endif

endmodule

### sv/mbwm_cmd_fifo.sv
// ----------------------------------------------------------------------------
// mbwm_cmd_fifo
// Short command queue between the byte front end and the execution back end.
// ----------------------------------------------------------------------------
module mbwm_cmd_fifo (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               wr_en,
    input  mbwm_pkg::mbwm_cmd_t wr_data,
    output logic               fifo_full,
    input  logic               rd_en,
    output mbwm_pkg::mbwm_cmd_t rd_data,
    output logic               fifo_empty
);
    import mbwm_pkg::*;

    mbwm_cmd_t              entry_reg [CMD_DEPTH];
    logic [CMD_PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [CMD_PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CMD_PTR_W:0]     count_reg, count_next;

    assign fifo_full  = (count_reg == (CMD_PTR_W+1)'(CMD_DEPTH));
    assign fifo_empty = (count_reg == '0);
    assign rd_data    = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en)
        begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (rd_en)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (wr_en && !rd_en)
            count_next = count_reg + 1'b1;
        else if (!wr_en && rd_en)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            entry_reg[wr_ptr_reg] <= wr_data;
    end

endmodule

### sv/mbwm_front.sv
// ----------------------------------------------------------------------------
// mbwm_front
// Tracks the frame position, keeps the header and its CRC, pairs data bytes
// and issues register-write and reply commands.
// ----------------------------------------------------------------------------
module mbwm_front #(
    parameter int unsigned REG_COUNT = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  mbwm_pkg::mbwm_in_t  rx,
    output logic                cmd_push,
    output mbwm_pkg::mbwm_cmd_t cmd
);
    import mbwm_pkg::*;

    logic [POS_W-1:0]        pos_reg, pos_next;
    logic [HDR_LEN-1:0][7:0] hdr_reg, hdr_next;
    logic [7:0]              hi_reg, hi_next;
    logic [15:0]             crc_reg, crc_next;

    logic                    pos_live;
    logic                    in_hdr;
    logic                    in_data;
    logic [POS_W-1:0]        pos_diff;
    logic [7:0]              pair_idx;
    logic [15:0]             start_addr;
    logic [15:0]             reg_cnt;
    logic [16:0]             addr_sum;
    logic                    in_bank;
    logic                    write_en;
    logic                    reply_en;

    assign pos_live   = (pos_reg != POS_MAX);
    assign in_hdr     = (pos_reg < POS_W'(HDR_LEN));
    assign in_data    = (pos_reg >= POS_W'(DATA_START));
    assign pos_diff   = pos_reg - POS_W'(DATA_START + 1);
    assign pair_idx   = pos_diff[POS_W-1:1];
    assign start_addr = {hdr_reg[2], hdr_reg[3]};
    assign reg_cnt    = {hdr_reg[4], hdr_reg[5]};
    assign addr_sum   = {1'b0, start_addr} + 17'(pair_idx);
    assign in_bank    = (addr_sum < 17'(REG_COUNT));

    assign write_en = accept && pos_live && in_data && !pos_reg[0]
                      && (16'(pair_idx) < reg_cnt) && in_bank;
    assign reply_en = accept && rx.frame_end && in_data;

    assign cmd_push     = write_en || reply_en;
    assign cmd.write_en = write_en;
    assign cmd.reply_en = reply_en;
    assign cmd.addr     = addr_sum[ADDR_W-1:0];
    assign cmd.data     = {hi_reg, rx.rx_byte};
    assign cmd.hdr      = hdr_reg;
    assign cmd.crc      = crc_reg;

    always_comb
    begin
        pos_next = pos_reg;
        hdr_next = hdr_reg;
        hi_next  = hi_reg;
        crc_next = crc_reg;
        if (accept)
        begin
            if (pos_live)
            begin
                if (in_hdr)
                begin
                    hdr_next[pos_reg[2:0]] = rx.rx_byte;
                    crc_next = crc_feed(crc_reg, rx.rx_byte);
                end
                else if (in_data && pos_reg[0])
                begin
                    hi_next = rx.rx_byte;
                end
                pos_next = pos_reg + 1'b1;
            end
            if (rx.frame_end)
            begin
                pos_next = '0;
                crc_next = CRC_INIT;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            hdr_reg <= '0;
            hi_reg  <= '0;
            crc_reg <= CRC_INIT;
        end
        else
        begin
            pos_reg <= pos_next;
            hdr_reg <= hdr_next;
            hi_reg  <= hi_next;
            crc_reg <= crc_next;
        end
    end

endmodule

### sv/mbwm_back.sv
// ----------------------------------------------------------------------------
// mbwm_back
// Executes commands: writes the register bank and serializes the eight-byte
// reply into the output register. Fills the bank with its start values after
// reset.
// ----------------------------------------------------------------------------
module mbwm_back #(
    parameter int unsigned REG_COUNT = 8
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cmd_valid,
    input  mbwm_pkg::mbwm_cmd_t  cmd,
    output logic                 cmd_pop,
    output logic                 init_busy,
    output logic                 tx_valid,
    output mbwm_pkg::mbwm_out_t  tx,
    input  logic                 pop
);
    import mbwm_pkg::*;

    localparam int unsigned AW = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;

    logic [15:0]             bank_mem [REG_COUNT];

    logic                    init_busy_reg, init_busy_next;
    logic [AW-1:0]           init_cnt_reg, init_cnt_next;

    logic                    active_reg, active_next;
    logic [HDR_LEN-1:0][7:0] hdr_buf_reg, hdr_buf_next;
    logic [15:0]             crc_buf_reg, crc_buf_next;
    logic [2:0]              idx_reg, idx_next;
    logic                    out_valid_reg, out_valid_next;
    mbwm_out_t               out_reg, out_next;

    logic                    out_take;
    logic                    ser_done;
    logic                    ser_free;
    logic [7:0]              cur_byte;

    assign init_busy = init_busy_reg;
    assign tx_valid  = out_valid_reg;
    assign tx        = out_reg;

    assign out_take = !out_valid_reg || pop;
    assign ser_done = active_reg && out_take && (idx_reg == 3'(REPLY_LEN - 1));
    assign ser_free = !active_reg || ser_done;
    assign cmd_pop  = cmd_valid && !init_busy_reg && (!cmd.reply_en || ser_free);

    always_comb
    begin
        case (idx_reg)
            3'd6:    cur_byte = crc_buf_reg[7:0];
            3'd7:    cur_byte = crc_buf_reg[15:8];
            default: cur_byte = hdr_buf_reg[idx_reg];
        endcase
    end

    always_comb
    begin
        init_busy_next = init_busy_reg;
        init_cnt_next  = init_cnt_reg;
        active_next    = active_reg;
        hdr_buf_next   = hdr_buf_reg;
        crc_buf_next   = crc_buf_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;

        if (init_busy_reg)
        begin
            if (init_cnt_reg == AW'(REG_COUNT - 1))
                init_busy_next = 1'b0;
            else
                init_cnt_next = init_cnt_reg + 1'b1;
        end

        if (out_valid_reg && pop)
            out_valid_next = 1'b0;

        if (active_reg && out_take)
        begin
            out_valid_next   = 1'b1;
            out_next.tx_byte = cur_byte;
            out_next.tx_last = ser_done;
            idx_next         = idx_reg + 1'b1;
            if (ser_done)
                active_next = 1'b0;
        end

        if (cmd_pop && cmd.reply_en)
        begin
            active_next  = 1'b1;
            hdr_buf_next = cmd.hdr;
            crc_buf_next = cmd.crc;
            idx_next     = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_busy_reg <= 1'b1;
            init_cnt_reg  <= '0;
            active_reg    <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            init_busy_reg <= init_busy_next;
            init_cnt_reg  <= init_cnt_next;
            active_reg    <= active_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hdr_buf_reg <= hdr_buf_next;
        crc_buf_reg <= crc_buf_next;
        out_reg     <= out_next;
    end

    always_ff @(posedge clk)
    begin
        if (init_busy_reg)
            bank_mem[init_cnt_reg] <= 16'(init_cnt_reg) + 16'd1;
        else if (cmd_pop && cmd.write_en)
            bank_mem[cmd.addr[AW-1:0]] <= cmd.data;
    end

endmodule
